// ===== src/cssf_pkg.sv =====
// ---------------------------------------------------------------------------
// cssf_pkg: shared types and constants for the command stream scalar finder
// Opcode limits, status codes, body length lookup and the result word.
// ---------------------------------------------------------------------------
`default_nettype none

package cssf_pkg;

    localparam int BYTE_W   = 8;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 3;
    localparam int LEFT_W   = 8;

    localparam logic [BYTE_W-1:0] OPC_TERM     = 8'h00;
    localparam logic [BYTE_W-1:0] OPC_LEN_PFX  = 8'hE0;
    localparam logic [BYTE_W-1:0] OPC_BAD_BASE = 8'hF0;
    localparam logic [BYTE_W-1:0] TARGET_LIMIT = 8'h60;

    localparam logic [2:0] CLS_SINGLE  = 3'd0;
    localparam logic [2:0] CLS_LEN_PFX = 3'd7;

    localparam logic [STATUS_W-1:0] ST_MATCH     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_TERM      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_MALFORMED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_AREA_END  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd4;

    typedef struct packed {
        logic [VALUE_W-1:0]  value;
        logic [STATUS_W-1:0] status;
    } cssf_result_t;

    // Body bytes that follow the opcode, by length class (2..16 for classes 1 to 6, else 0).
    function automatic logic [LEFT_W-1:0] body_len(input logic [2:0] cls);
        logic [LEFT_W-1:0] len;
        case (cls)
            3'd1:    len = 8'd2;
            3'd2:    len = 8'd4;
            3'd3:    len = 8'd6;
            3'd4:    len = 8'd8;
            3'd5:    len = 8'd12;
            3'd6:    len = 8'd16;
            default: len = 8'd0;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

// ===== src/cssf_scan.sv =====
// ---------------------------------------------------------------------------
// cssf_scan: input register and command framing step
// Registers one area word, then runs one scan step on it against the
// held scan state and raises a result when the scan ends.
// ---------------------------------------------------------------------------
`default_nettype none

module cssf_scan (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_wr_en,
    input  wire logic [cssf_pkg::BYTE_W-1:0] cfg_wr_data,
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    input  wire logic [cssf_pkg::BYTE_W-1:0] s_axis_tdata,
    input  wire logic                       s_axis_tuser,
    input  wire logic                       s_axis_tlast,
    output logic                            res_valid,
    input  wire logic                       res_ready,
    output cssf_pkg::cssf_result_t          res
);
    import cssf_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_OPCODE,
        PH_BODY,
        PH_LENBYTE,
        PH_PAYLOAD
    } phase_t;

    logic               in_valid_reg;
    logic [BYTE_W-1:0]  in_byte_reg;
    logic               in_first_reg;
    logic               in_last_reg;
    logic [BYTE_W-1:0]  target_reg;

    phase_t             phase_reg, phase_next;
    logic [LEFT_W-1:0]  left_reg, left_next;
    logic               match_reg, match_next;
    logic [VALUE_W-1:0] acc_reg, acc_next;

    logic               advance;
    logic               fin;
    logic               target_oor;
    logic               hit;
    logic [2:0]         cls;
    phase_t             ph;
    logic [LEFT_W-1:0]  left_dec;
    logic [VALUE_W-1:0] acc_shift;
    logic [VALUE_W-1:0] fin_value;
    logic [STATUS_W-1:0] fin_status;

    // A word leaves the input register only when the result side can take it.
    assign advance       = in_valid_reg && res_ready;
    assign s_axis_tready = !in_valid_reg || advance;

    assign target_oor = (target_reg >= TARGET_LIMIT);
    assign cls        = in_byte_reg[7:5];
    assign hit        = !target_oor && (in_byte_reg == target_reg);
    assign acc_shift  = {acc_reg[VALUE_W-BYTE_W-1:0], in_byte_reg};

    always_comb begin
        phase_next = phase_reg;
        left_next  = left_reg;
        match_next = match_reg;
        acc_next   = acc_reg;
        fin        = 1'b0;
        fin_value  = '0;
        fin_status = ST_MATCH;
        ph         = phase_reg;
        left_dec   = left_reg - 8'd1;

        if (in_first_reg) begin
            left_next  = '0;
            match_next = 1'b0;
            acc_next   = '0;
            left_dec   = '0;
            if (target_oor) begin
                fin        = 1'b1;
                fin_status = ST_RANGE;
                ph         = PH_IDLE;
            end else begin
                ph = PH_OPCODE;
            end
        end

        case (ph)
            PH_OPCODE: begin
                if (in_byte_reg == OPC_TERM) begin
                    fin        = 1'b1;
                    fin_status = ST_TERM;
                end else if (in_byte_reg >= OPC_BAD_BASE) begin
                    fin        = 1'b1;
                    fin_status = ST_MALFORMED;
                end else if (cls == CLS_LEN_PFX) begin
                    phase_next = PH_LENBYTE;
                    if (in_last_reg) begin
                        fin        = 1'b1;
                        fin_status = ST_MALFORMED;
                    end
                end else if (cls == CLS_SINGLE) begin
                    phase_next = PH_OPCODE;
                    if (hit) begin
                        fin        = 1'b1;
                        fin_value  = VALUE_W'(1);
                        fin_status = ST_MATCH;
                    end else if (in_last_reg) begin
                        fin        = 1'b1;
                        fin_status = ST_AREA_END;
                    end
                end else begin
                    left_next  = body_len(cls);
                    match_next = hit;
                    acc_next   = '0;
                    phase_next = PH_BODY;
                    if (in_last_reg) begin
                        fin        = 1'b1;
                        fin_status = ST_MALFORMED;
                    end
                end
            end
            PH_BODY: begin
                acc_next  = acc_shift;
                left_next = left_dec;
                if (left_dec == '0) begin
                    phase_next = PH_OPCODE;
                    if (match_reg) begin
                        fin        = 1'b1;
                        fin_value  = acc_shift;
                        fin_status = ST_MATCH;
                    end else if (in_last_reg) begin
                        fin        = 1'b1;
                        fin_status = ST_AREA_END;
                    end
                end else if (in_last_reg) begin
                    fin        = 1'b1;
                    fin_status = ST_MALFORMED;
                end
            end
            PH_LENBYTE: begin
                left_next = in_byte_reg;
                if (in_byte_reg == '0) begin
                    phase_next = PH_OPCODE;
                    if (in_last_reg) begin
                        fin        = 1'b1;
                        fin_status = ST_AREA_END;
                    end
                end else begin
                    phase_next = PH_PAYLOAD;
                    if (in_last_reg) begin
                        fin        = 1'b1;
                        fin_status = ST_MALFORMED;
                    end
                end
            end
            PH_PAYLOAD: begin
                left_next = left_dec;
                if (left_dec == '0) begin
                    phase_next = PH_OPCODE;
                    if (in_last_reg) begin
                        fin        = 1'b1;
                        fin_status = ST_AREA_END;
                    end
                end else if (in_last_reg) begin
                    fin        = 1'b1;
                    fin_status = ST_MALFORMED;
                end
            end
            default: begin
                // idle: drop the word
            end
        endcase

        // End of scan clears everything until the next first word.
        if (fin) begin
            phase_next = PH_IDLE;
            left_next  = '0;
            match_next = 1'b0;
            acc_next   = '0;
        end
    end

    assign res_valid  = in_valid_reg && fin;
    assign res.value  = fin_value;
    assign res.status = fin_status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            target_reg   <= '0;
            phase_reg    <= PH_IDLE;
            left_reg     <= '0;
            match_reg    <= 1'b0;
            acc_reg      <= '0;
        end else begin
            if (cfg_wr_en) begin
                target_reg <= cfg_wr_data;
            end
            if (s_axis_tready) begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance) begin
                phase_reg <= phase_next;
                left_reg  <= left_next;
                match_reg <= match_next;
                acc_reg   <= acc_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_byte_reg  <= s_axis_tdata;
            in_first_reg <= s_axis_tuser;
            in_last_reg  <= s_axis_tlast;
        end
    end

    a_idle_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_IDLE) |-> (left_reg == '0 && !match_reg && acc_reg == '0))
        else $error("idle scan holds stale state");

    a_body_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_BODY) |-> (left_reg != '0 && left_reg <= 8'd16))
        else $error("body count out of range");

    a_payload_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_PAYLOAD) |-> (left_reg != '0))
        else $error("payload phase with nothing left");

    a_result_ends_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && fin) |=> (phase_reg == PH_IDLE))
        else $error("scan continues after result");

    a_match_only_body: assert property (@(posedge aclk) disable iff (!aresetn)
        match_reg |-> (phase_reg == PH_BODY))
        else $error("match flag outside a command body");

endmodule

`default_nettype wire

// ===== src/cssf_out.sv =====
// ---------------------------------------------------------------------------
// cssf_out: result register
// Holds one finished result word until the downstream side takes it.
// ---------------------------------------------------------------------------
`default_nettype none

module cssf_out (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         res_valid,
    output logic                              res_ready,
    input  wire cssf_pkg::cssf_result_t       res,
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    output logic [cssf_pkg::VALUE_W-1:0]      m_axis_tdata,
    output logic [cssf_pkg::STATUS_W-1:0]     m_axis_tuser
);
    import cssf_pkg::*;

    logic         out_valid_reg;
    cssf_result_t out_data_reg;

    assign res_ready     = !out_valid_reg || m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg.value;
    assign m_axis_tuser  = out_data_reg.status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_ready) begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_data_reg <= res;
        end
    end

    a_status_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_data_reg.status <= ST_RANGE))
        else $error("illegal end status held");

    a_value_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_data_reg.status != ST_MATCH) |-> (out_data_reg.value == '0))
        else $error("nonzero value without a match");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_axis_tready) |-> !res_ready)
        else $error("pending result could be overwritten");

endmodule

`default_nettype wire

// ===== src/command_stream_scalar_finder.sv =====
// Result path: the word that ends the scan is held in the input register, and its
// result is then held in the result register that drives m_axis.
// Throughput: one area word per cycle while m_axis_tready stays high; a result
// waiting downstream stalls the input once the input register holds a word.
// Reset: aresetn low clears the scan to idle, drops held words and sets
// target_opcode to zero.
// ---------------------------------------------------------------------------
// command_stream_scalar_finder: frames a command area and reports one scalar
// Scans variable-length commands byte by byte and returns the body of the first
// command whose opcode equals the configured target, or 1 for a bodyless one.
// ---------------------------------------------------------------------------
`default_nettype none

module command_stream_scalar_finder (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [cssf_pkg::BYTE_W-1:0]   cfg_wr_data,    // target_opcode
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [cssf_pkg::BYTE_W-1:0]   s_axis_tdata,   // [7:0] area_byte
    input  wire logic                          s_axis_tuser,   // [0] first_byte
    input  wire logic                          s_axis_tlast,   // last_byte
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [cssf_pkg::VALUE_W-1:0]       m_axis_tdata,   // [31:0] found_value
    output logic [cssf_pkg::STATUS_W-1:0]      m_axis_tuser    // [2:0] end_status
);
    import cssf_pkg::*;

    logic         res_valid;
    logic         res_ready;
    cssf_result_t res;

    cssf_scan u_scan (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res           (res)
    );

    cssf_out u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res           (res),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire
